### rtl/core/palette_merge_allocator_assert.svh
// ----------------------------------------------------------------------------
// palette_merge_allocator_assert.svh
// Assertion macros shared by the palette merge allocator RTL.
// ----------------------------------------------------------------------------
`ifndef PALETTE_MERGE_ALLOCATOR_ASSERT_SVH
`define PALETTE_MERGE_ALLOCATOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PMA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PMA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/pma_pkg.sv
// ----------------------------------------------------------------------------
// pma_pkg
// Shared types, codes and constants of the palette merge allocator.
// ----------------------------------------------------------------------------
package pma_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT  = 256;
   localparam int RESERVED_ENTRIES_DEFAULT = 16;
   localparam int RESET_FREE_SLOT          = 16;
   localparam int INDEX_W                  = 8;
   localparam int COLOR_W                  = 32;
   localparam int STATUS_W                 = 3;
   localparam int ALPHA_LSB                = 24;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_LOAD  = 2'd1,
      OP_MAP   = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 3'd0,
      ST_MATCH = 3'd1,
      ST_NEW   = 3'd2,
      ST_SKIP  = 3'd3,
      ST_FAIL  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_COPY,
      S_DRAIN,
      S_SCAN,
      S_READ,
      S_FINISH
   } state_type;

   // Result kind the datapath stages for the current item
   typedef enum logic [2:0] {
      POST_NONE,
      POST_DONE,
      POST_FAIL,
      POST_SKIP,
      POST_HIT,
      POST_MISS,
      POST_READ
   } post_type;

   typedef struct packed {
      logic     capture;
      logic     load_base;
      logic     copy_step;
      logic     start_commit;
      logic     scan_step;
      logic     rd_issue;
      logic     load_rsp;
      post_type post;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       failed;
      logic       transparent;
      logic       copy_last;
      logic       issue_more;
      logic       hit;
   } sts_type;

endpackage

### rtl/core/pma_ctrl.sv
// ----------------------------------------------------------------------------
// pma_ctrl
// Sequencer: request/result handshake and per-opcode command sequencing.
// ----------------------------------------------------------------------------
module pma_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  pma_pkg::sts_type sts,
   output pma_pkg::cmd_type cmd
);
   import pma_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.post = POST_NONE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.op)
               OP_START: state_in = S_COPY;
               OP_LOAD: begin
                  cmd.load_base = 1'b1;
                  cmd.post      = POST_DONE;
                  state_in      = S_FINISH;
               end
               OP_READ: begin
                  cmd.rd_issue = 1'b1;
                  state_in     = S_READ;
               end
               OP_MAP: begin
                  if (sts.failed) begin
                     cmd.post = POST_FAIL;
                     state_in = S_FINISH;
                  end else if (sts.transparent) begin
                     cmd.post = POST_SKIP;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (sts.copy_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last copy write lands this cycle
            cmd.start_commit = 1'b1;
            cmd.post         = POST_DONE;
            state_in         = S_FINISH;
         end
         S_SCAN: begin
            if (sts.hit) begin
               cmd.post = POST_HIT;
               state_in = S_FINISH;
            end else if (sts.issue_more) begin
               cmd.scan_step = 1'b1;
            end else begin
               cmd.post = POST_MISS;
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            cmd.post = POST_READ;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold the staged result until the output register frees up
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule

### rtl/core/pma_datapath.sv
// ----------------------------------------------------------------------------
// pma_datapath
// Base and working palette memories, scan counter, slot allocation and
// result registers.
// ----------------------------------------------------------------------------
module pma_datapath #(
   parameter int PALETTE_ENTRIES  = pma_pkg::PALETTE_ENTRIES_DEFAULT,
   parameter int RESERVED_ENTRIES = pma_pkg::RESERVED_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_opcode,
   input  logic [pma_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [pma_pkg::COLOR_W-1:0]  req_color_value,
   output logic [pma_pkg::INDEX_W-1:0]  rsp_slot_index,
   output logic [pma_pkg::STATUS_W-1:0] rsp_status,
   output logic [pma_pkg::COLOR_W-1:0]  rsp_read_value,
   input  pma_pkg::cmd_type             cmd,
   output pma_pkg::sts_type             sts
);
   import pma_pkg::*;

   localparam int ADDR_W  = $clog2(PALETTE_ENTRIES);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int RES_CAP = (RESERVED_ENTRIES > PALETTE_ENTRIES) ?
                            PALETTE_ENTRIES : RESERVED_ENTRIES;

   logic [COLOR_W-1:0] base_mem [PALETTE_ENTRIES];
   logic [COLOR_W-1:0] work_mem [PALETTE_ENTRIES];

   opcode_type          op_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    next_free_ff;
   logic                failed_ff;
   logic                rd_valid_ff;
   logic [ADDR_W-1:0]   scan_addr_ff;
   logic                copy_wr_ff;
   logic [ADDR_W-1:0]   copy_wa_ff;
   logic [COLOR_W-1:0]  base_rd_ff;
   logic [COLOR_W-1:0]  work_rd_ff;
   logic                rd_ok_ff;

   logic [INDEX_W-1:0]  res_index_ff;
   status_type          res_status_ff;
   logic [COLOR_W-1:0]  res_read_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   status_type          rsp_status_ff;
   logic [COLOR_W-1:0]  rsp_read_ff;

   logic [CNT_W-1:0]    lim;
   logic                full;
   logic                idx_ok;
   logic                hit;
   logic                work_we;
   logic [ADDR_W-1:0]   work_wa;
   logic [COLOR_W-1:0]  work_wd;
   logic                work_re;
   logic [ADDR_W-1:0]   work_ra;

   assign lim    = (next_free_ff > CNT_W'(PALETTE_ENTRIES)) ?
                   CNT_W'(PALETTE_ENTRIES) : next_free_ff;
   assign full   = (next_free_ff >= CNT_W'(PALETTE_ENTRIES));
   assign idx_ok = ({1'b0, idx_ff} < (INDEX_W + 1)'(PALETTE_ENTRIES));
   assign hit    = rd_valid_ff && (work_rd_ff == color_ff);

   assign sts.op          = op_ff;
   assign sts.failed      = failed_ff;
   assign sts.transparent = (color_ff[COLOR_W-1:ALPHA_LSB] == '0);
   assign sts.copy_last   = (cnt_ff == CNT_W'(PALETTE_ENTRIES - 1));
   assign sts.issue_more  = (cnt_ff < lim);
   assign sts.hit         = hit;

   // working palette port: copy and allocation share the write side
   assign work_we = copy_wr_ff || ((cmd.post == POST_MISS) && !full);
   assign work_wa = copy_wr_ff ? copy_wa_ff : next_free_ff[ADDR_W-1:0];
   assign work_wd = copy_wr_ff ? base_rd_ff : color_ff;
   assign work_re = cmd.scan_step || cmd.rd_issue;
   assign work_ra = cmd.rd_issue ? idx_ff[ADDR_W-1:0] : cnt_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_base && idx_ok) begin
         base_mem[idx_ff[ADDR_W-1:0]] <= color_ff;
      end
      if (cmd.copy_step) begin
         base_rd_ff <= base_mem[cnt_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_wa] <= work_wd;
      end
      if (work_re) begin
         work_rd_ff <= work_mem[work_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= CNT_W'(RESET_FREE_SLOT);
         failed_ff    <= 1'b0;
         rd_valid_ff  <= 1'b0;
         copy_wr_ff   <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_step;
         copy_wr_ff  <= cmd.copy_step;
         if (cmd.start_commit) begin
            next_free_ff <= CNT_W'(RES_CAP);
            failed_ff    <= 1'b0;
         end else if (cmd.post == POST_MISS) begin
            if (full) begin
               failed_ff <= 1'b1;
            end else begin
               next_free_ff <= next_free_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= opcode_type'(req_opcode);
         idx_ff   <= req_entry_index;
         color_ff <= req_color_value;
         cnt_ff   <= '0;
      end else if (cmd.copy_step || cmd.scan_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.copy_step) begin
         copy_wa_ff <= cnt_ff[ADDR_W-1:0];
      end
      if (cmd.scan_step) begin
         scan_addr_ff <= cnt_ff[ADDR_W-1:0];
      end
      if (cmd.rd_issue) begin
         rd_ok_ff <= idx_ok;
      end
   end

   // stage the result of the current item
   always_ff @(posedge clock) begin
      case (cmd.post)
         POST_DONE: begin
            res_index_ff  <= '0;
            res_status_ff <= ST_DONE;
            res_read_ff   <= '0;
         end
         POST_FAIL: begin
            res_index_ff  <= '0;
            res_status_ff <= ST_FAIL;
            res_read_ff   <= '0;
         end
         POST_SKIP: begin
            res_index_ff  <= '0;
            res_status_ff <= ST_SKIP;
            res_read_ff   <= '0;
         end
         POST_HIT: begin
            res_index_ff  <= INDEX_W'(scan_addr_ff);
            res_status_ff <= ST_MATCH;
            res_read_ff   <= '0;
         end
         POST_MISS: begin
            res_index_ff  <= full ? '0 : INDEX_W'(next_free_ff[ADDR_W-1:0]);
            res_status_ff <= full ? ST_FAIL : ST_NEW;
            res_read_ff   <= '0;
         end
         POST_READ: begin
            res_index_ff  <= '0;
            res_status_ff <= ST_DONE;
            res_read_ff   <= rd_ok_ff ? work_rd_ff : '0;
         end
         default: begin
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_index_ff  <= res_index_ff;
         rsp_status_ff <= res_status_ff;
         rsp_read_ff   <= res_read_ff;
      end
   end

   assign rsp_slot_index = rsp_index_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_ff;

endmodule

### rtl/core/palette_merge_allocator.sv
// ----------------------------------------------------------------------------
// palette_merge_allocator
// Shared ARGB palette builder with first-fit color merging.
//
// Request channel (req_*): opcode, entry index and color word, valid/ready.
// Result channel (rsp_*): slot index, status and read word, valid/ready;
// exactly one result per item, in order. One item is worked at a time and
// req_ready is high only while idle. A load of a base entry, or a map while
// failed or transparent, goes straight to its result. A read entry is a
// registered memory read. A start copies one base word per cycle. A map
// compares one stored word per cycle over the occupied slots and returns
// the first match; on a miss it takes the next free slot.
// A new item is accepted at the earliest at the edge after the previous result
// is registered. A stalled receiver holds the next result in its finish step,
// which keeps req_ready low. Reset clears the handshake, sets the free slot to
// sixteen and clears the failed flag; load and start the palettes before use.
// ----------------------------------------------------------------------------
module palette_merge_allocator #(
   parameter int PALETTE_ENTRIES  = pma_pkg::PALETTE_ENTRIES_DEFAULT,
   parameter int RESERVED_ENTRIES = pma_pkg::RESERVED_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic [pma_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [pma_pkg::COLOR_W-1:0]  req_color_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pma_pkg::INDEX_W-1:0]  rsp_slot_index,
   output logic [pma_pkg::STATUS_W-1:0] rsp_status,
   output logic [pma_pkg::COLOR_W-1:0]  rsp_read_value
);
   import pma_pkg::*;

   `include "palette_merge_allocator_assert.svh"

   cmd_type cmd;
   sts_type sts;
   logic    map_result;
   logic    done_result;

   assign map_result  = (rsp_status == 3'(ST_MATCH)) || (rsp_status == 3'(ST_NEW));
   assign done_result = (rsp_status == 3'(ST_DONE));

   pma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pma_datapath #(
      .PALETTE_ENTRIES  (PALETTE_ENTRIES),
      .RESERVED_ENTRIES (RESERVED_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_entry_index  (req_entry_index),
      .req_color_value  (req_color_value),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .cmd              (cmd),
      .sts              (sts)
   );

   `PMA_ASSERT_ALWAYS(a_reset_idle, reset |=> (req_ready && !rsp_valid), "not idle after reset")
   `PMA_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "accepted while busy")
   `PMA_ASSERT(a_rsp_after_work, $rose(rsp_valid) |-> !$past(req_ready), "result without work")
   `PMA_ASSERT(a_index_zero, (rsp_valid && !map_result) |-> (rsp_slot_index == '0), "slot off a map")
   `PMA_ASSERT(a_read_zero, (rsp_valid && !done_result) |-> (rsp_read_value == '0), "read word on map")

endmodule

### sim/pma_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pma_result_checker
// Watches both channels of the palette merge allocator. It keeps its own copy
// of the base and working palettes, works out the result of every accepted
// item, and compares each returned item field by field, in order.
// ----------------------------------------------------------------------------
module pma_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_entry_index,
   input  logic [31:0] req_color_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_slot_index,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_read_value,
   output int          mismatches,
   output int          pending_results,
   output int          matched_maps,
   output int          allocated_maps,
   output int          skipped_maps,
   output int          failed_maps
);
   import pma_pkg::*;

   localparam int PAL_SIZE = (PALETTE_ENTRIES_DEFAULT > 256) ? 256 : PALETTE_ENTRIES_DEFAULT;
   localparam int RESERVED = (RESERVED_ENTRIES_DEFAULT > PAL_SIZE) ?
                             PAL_SIZE : RESERVED_ENTRIES_DEFAULT;

   typedef struct packed {
      logic [INDEX_W-1:0] slot;
      status_type         status;
      logic [COLOR_W-1:0] word;
   } palette_result_type;

   logic [COLOR_W-1:0] base_words [PAL_SIZE];
   logic [COLOR_W-1:0] work_words [PAL_SIZE];
   logic [8:0]         free_slot;
   logic               map_failed;
   palette_result_type due_q [$];

   // Advance the palette state by one item and return what the block owes for it
   function automatic palette_result_type apply_item(opcode_type op,
                                                     logic [INDEX_W-1:0] idx,
                                                     logic [COLOR_W-1:0] color);
      palette_result_type r;
      int hit;
      r.slot   = '0;
      r.status = ST_DONE;
      r.word   = '0;
      hit      = -1;
      case (op)
         OP_START: begin
            for (int i = 0; i < PAL_SIZE; i++) work_words[i] = base_words[i];
            free_slot  = 9'(RESERVED);
            map_failed = 1'b0;
         end
         OP_LOAD: begin
            if (idx < PAL_SIZE) base_words[idx] = color;
         end
         OP_READ: begin
            if (idx < PAL_SIZE) r.word = work_words[idx];
         end
         default: begin
            if (map_failed) begin
               r.status = ST_FAIL;
            end else if (color[ALPHA_LSB +: 8] == 8'h00) begin
               r.status = ST_SKIP;
            end else begin
               // first fit among the occupied slots only
               for (int i = 0; i < PAL_SIZE && i < free_slot; i++) begin
                  if (hit < 0 && work_words[i] == color) hit = i;
               end
               if (hit >= 0) begin
                  r.slot   = hit[7:0];
                  r.status = ST_MATCH;
               end else if (free_slot >= PAL_SIZE) begin
                  map_failed = 1'b1;
                  r.status   = ST_FAIL;
               end else begin
                  r.slot                   = free_slot[7:0];
                  work_words[free_slot[7:0]] = color;
                  free_slot                = free_slot + 9'd1;
                  r.status                 = ST_NEW;
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      palette_result_type want;
      if (reset) begin
         free_slot  = 9'(RESET_FREE_SLOT);
         map_failed = 1'b0;
         due_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            due_q.push_back(apply_item(opcode_type'(req_opcode), req_entry_index,
                                       req_color_value));
         end
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               $display("%0t: unexpected item: expected none, got slot %0d status %0d word %h",
                        $time, rsp_slot_index, rsp_status, rsp_read_value);
               mismatches++;
            end else begin
               want = due_q.pop_front();
               if (rsp_slot_index !== want.slot) begin
                  $display("%0t: slot index expected %0d, got %0d",
                           $time, want.slot, rsp_slot_index);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_read_value !== want.word) begin
                  $display("%0t: read_value expected %h, got %h",
                           $time, want.word, rsp_read_value);
                  mismatches++;
               end
               case (want.status)
                  ST_MATCH: matched_maps++;
                  ST_NEW:   allocated_maps++;
                  ST_SKIP:  skipped_maps++;
                  ST_FAIL:  failed_maps++;
                  default: ;
               endcase
            end
         end
      end
      pending_results = due_q.size();
   end

endmodule

### sim/tb_palette_merge_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_merge_allocator
// Loads a base palette, runs a short directed pass over the color merge
// rules, then random sessions of start, map, read and load items, two of
// which run the palette out of slots. Both channels stall at random; once
// the result side holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_palette_merge_allocator;
   import pma_pkg::*;

   localparam int TOTAL_ITEMS = 950;
   localparam int PHASE2_AT   = 500;
   localparam int PHASE3_AT   = 850;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 300;
   localparam int POOL_DEPTH  = 64;
   localparam int FILL_MAPS   = 290;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_opcode;
   logic [INDEX_W-1:0] req_entry_index;
   logic [COLOR_W-1:0] req_color_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [INDEX_W-1:0] rsp_slot_index;
   logic [STATUS_W-1:0] rsp_status;
   logic [COLOR_W-1:0] rsp_read_value;

   int mismatches, pending_results;
   int matched_maps, allocated_maps, skipped_maps, failed_maps;
   int send_idle_pct = 35;
   int recv_idle_pct = 76;
   int items_sent;
   int quiet_cycles;
   logic hold_go   = 1'b0;
   logic hold_done = 1'b0;

   logic [COLOR_W-1:0] base_copy [256];
   logic [COLOR_W-1:0] color_pool [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   palette_merge_allocator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_entry_index  (req_entry_index),
      .req_color_value  (req_color_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value)
   );

   pma_result_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_entry_index  (req_entry_index),
      .req_color_value  (req_color_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .mismatches       (mismatches),
      .pending_results  (pending_results),
      .matched_maps     (matched_maps),
      .allocated_maps   (allocated_maps),
      .skipped_maps     (skipped_maps),
      .failed_maps      (failed_maps)
   );

   // Offer one item and hold it until accepted; called at a rising edge
   task automatic send_item(input opcode_type op, input logic [INDEX_W-1:0] idx,
                            input logic [COLOR_W-1:0] color);
      if (items_sent >= PHASE3_AT) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
         hold_go       = 1'b1;
      end else if (items_sent >= PHASE2_AT) begin
         send_idle_pct = 76;
         recv_idle_pct = 35;
      end
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_color_value <= color;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic load_base(input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] color);
      base_copy[idx] = color;
      send_item(OP_LOAD, idx, color);
   endtask

   task automatic map_color(input logic [COLOR_W-1:0] color);
      send_item(OP_MAP, INDEX_W'($urandom), color);
   endtask

   function automatic logic [COLOR_W-1:0] fresh_color();
      logic [COLOR_W-1:0] c;
      c = $urandom;
      color_pool.push_back(c);
      if (color_pool.size() > POOL_DEPTH) void'(color_pool.pop_front());
      return c;
   endfunction

   // Mostly colors seen before, so that matches are common
   function automatic logic [COLOR_W-1:0] pick_color();
      int r;
      r = $urandom_range(99);
      if (r < 40 && color_pool.size() != 0)
         return color_pool[$urandom_range(color_pool.size() - 1)];
      if (r < 60) return base_copy[$urandom_range(255)];
      if (r < 68) return {8'h00, 24'($urandom)};
      return fresh_color();
   endfunction

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending_results);
         $display("tb_palette_merge_allocator: errors");
         $finish;
      end
   end

   initial begin
      int session;
      int span;
      int pick;
      logic [COLOR_W-1:0] c;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= OP_START;
      req_entry_index <= '0;
      req_color_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Base palette: duplicates and a transparent word inside the reserved range
      for (int i = 0; i < 256; i++) begin
         c = {8'($urandom_range(1, 255)), 24'($urandom)};
         case (i)
            0:       c = 32'hFFFF_FFFF;
            1:       c = 32'h0000_0000;
            7:       c = 32'h00AB_CDEF;
            10:      c = base_copy[3];
            200:     c = base_copy[5];
            default: ;
         endcase
         load_base(INDEX_W'(i), c);
      end

      send_item(OP_START, 8'hFF, 32'hFFFF_FFFF);
      send_item(OP_READ, 8'h00, 32'h0000_0000);
      send_item(OP_READ, 8'hFF, 32'hFFFF_FFFF);
      map_color(base_copy[10]);      // duplicate of a lower slot: lowest wins
      map_color(base_copy[15]);
      map_color(base_copy[100]);     // in the working copy but not occupied
      map_color(base_copy[100]);
      map_color(32'h00FF_FFFF);      // zero alpha, all other bits set
      map_color(base_copy[7]);       // transparent even though it is stored
      map_color(32'hFFFF_FFFF);
      map_color(32'h0100_0000);      // smallest nonzero alpha
      send_item(OP_READ, 8'd16, 32'hFFFF_FFFF);
      load_base(8'hFF, 32'h8000_0001);
      load_base(8'h00, 32'h0000_0000);
      send_item(OP_READ, 8'h00, 32'h0000_0000);   // working copy keeps the old word
      send_item(OP_START, 8'h00, 32'h0000_0000);
      send_item(OP_READ, 8'h00, 32'h0000_0000);
      send_item(OP_READ, 8'hFF, 32'h0000_0000);
      map_color(32'hFFFF_FFFF);

      session = 0;
      while (items_sent < TOTAL_ITEMS) begin
         send_item(OP_START, INDEX_W'($urandom), $urandom);
         if (session == 1 || session == 3) begin
            // run out of slots, then poke the block while it is failed
            repeat (FILL_MAPS) begin
               if ($urandom_range(99) < 92) map_color(fresh_color());
               else map_color(pick_color());
            end
            repeat (12) begin
               pick = $urandom_range(2);
               if (pick == 0) map_color(pick_color());
               else if (pick == 1) map_color({8'h00, 24'($urandom)});
               else send_item(OP_READ, INDEX_W'($urandom), $urandom);
            end
         end else begin
            span = $urandom_range(20, 60);
            repeat (span) begin
               pick = $urandom_range(99);
               if (pick < 60) map_color(pick_color());
               else if (pick < 76) send_item(OP_READ, INDEX_W'($urandom), $urandom);
               else if (pick < 92) load_base(INDEX_W'($urandom), $urandom);
               else if (pick < 95) send_item(OP_START, INDEX_W'($urandom), $urandom);
               else map_color({8'h00, 24'($urandom)});
            end
         end
         session++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d items in %0d sessions: %0d maps matched, %0d allocated, %0d skipped, %0d failed",
               items_sent, session, matched_maps, allocated_maps, skipped_maps, failed_maps);
      $display("long result stall done: %0d, field mismatches: %0d", hold_done, mismatches);
      if (mismatches == 0) $display("tb_palette_merge_allocator: clean");
      else $display("tb_palette_merge_allocator: errors");
      $finish;
   end

endmodule
